FILE: hw/rtl/u8u16_pkg.sv
// Package for the UTF-8 to UTF-16 decoder: field widths, byte class
// constants and the state and result structs. No dependencies.
package u8u16_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned UnitW  = 16;
	localparam int unsigned PendW  = 2;
	localparam int unsigned PartW  = 10;
	localparam int unsigned CountW = 16;

	localparam logic [UnitW-1:0]  UnitZero  = '0;
	localparam logic [CountW-1:0] CountMax  = '1;

	// Continuation bytes still expected.
	localparam logic [PendW-1:0] PendNone = 2'd0;
	localparam logic [PendW-1:0] PendOne  = 2'd1;
	localparam logic [PendW-1:0] PendTwo  = 2'd2;

	// Byte class prefixes.
	localparam logic [1:0] ContTag  = 2'b10;
	localparam logic [2:0] Lead2Tag = 3'b110;
	localparam logic [3:0] Lead3Tag = 4'b1110;

	typedef struct packed {
		logic [PendW-1:0]  pending;
		logic [PartW-1:0]  partial;
		logic              err;
		logic [CountW-1:0] count;
	} dec_state_t;

	typedef struct packed {
		logic              unit_valid;
		logic [UnitW-1:0]  code_unit;
		logic              byte_error;
		logic              string_end;
		logic              string_error;
		logic [CountW-1:0] unit_total;
	} dec_result_t;

endpackage

FILE: hw/rtl/u8u16_byte_if.sv
// Input channel: one UTF-8 byte per transfer with an end-of-string flag.
// Depends on u8u16_pkg.
interface u8u16_byte_if;
	import u8u16_pkg::*;

	logic             valid;
	logic             ready;
	logic [ByteW-1:0] byte_in;
	logic             last_byte;

	modport source (output valid, output byte_in, output last_byte, input ready);
	modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

FILE: hw/rtl/u8u16_unit_if.sv
// Output channel: one decode result per transfer.
// Depends on u8u16_pkg.
interface u8u16_unit_if;
	import u8u16_pkg::*;

	logic              valid;
	logic              ready;
	logic              unit_valid;
	logic [UnitW-1:0]  code_unit;
	logic              byte_error;
	logic              string_end;
	logic              string_error;
	logic [CountW-1:0] unit_total;

	modport source (
		output valid, output unit_valid, output code_unit, output byte_error,
		output string_end, output string_error, output unit_total, input ready
	);
	modport sink (
		input valid, input unit_valid, input code_unit, input byte_error,
		input string_end, input string_error, input unit_total, output ready
	);
endinterface

FILE: hw/rtl/u8u16_decode.sv
// Combinational decode of one byte against the current sequence state.
// Produces the next state and the result item. Depends on u8u16_pkg.
module u8u16_decode (
	input  u8u16_pkg::dec_state_t       cur,
	input  logic [u8u16_pkg::ByteW-1:0] byte_in,
	input  logic                        last_byte,
	output u8u16_pkg::dec_state_t       nxt,
	output u8u16_pkg::dec_result_t      res
);
	import u8u16_pkg::*;

	logic              is_cont;
	logic              emit;
	logic              bad;
	logic [UnitW-1:0]  unit;
	logic [UnitW-1:0]  joined;
	logic [PendW-1:0]  pend_n;
	logic [PartW-1:0]  part_n;
	logic              err_n;
	logic [CountW-1:0] count_n;

	assign is_cont = (byte_in[7:6] == ContTag);
	assign joined  = {cur.partial, byte_in[5:0]};

	always_comb begin
		emit   = 1'b0;
		bad    = 1'b0;
		unit   = UnitZero;
		pend_n = PendNone;
		part_n = '0;
		if (cur.pending != PendNone && is_cont) begin
			if (cur.pending == PendOne) begin
				emit = 1'b1;
				unit = joined;
			end else begin
				pend_n = PendOne;
				part_n = joined[PartW-1:0];
			end
		end else begin
			// Lead byte; a broken sequence is dropped and this byte retried as a lead.
			bad = (cur.pending != PendNone);
			if (!byte_in[7]) begin
				emit = 1'b1;
				unit = {{(UnitW-ByteW){1'b0}}, byte_in};
			end else if (byte_in[7:5] == Lead2Tag) begin
				pend_n = PendOne;
				part_n = {5'd0, byte_in[4:0]};
			end else if (byte_in[7:4] == Lead3Tag) begin
				pend_n = PendTwo;
				part_n = {6'd0, byte_in[3:0]};
			end else begin
				bad = 1'b1;
			end
		end
	end

	assign err_n   = cur.err | bad;
	assign count_n = (emit && cur.count != CountMax) ? cur.count + 1'b1 : cur.count;

	always_comb begin
		res.unit_valid   = emit;
		res.code_unit    = unit;
		res.byte_error   = bad;
		res.string_end   = last_byte;
		res.string_error = 1'b0;
		res.unit_total   = '0;
		nxt.pending      = pend_n;
		nxt.partial      = part_n;
		nxt.err          = err_n;
		nxt.count        = count_n;
		if (last_byte) begin
			// Summarize, flag truncation, and clear for the next string.
			res.string_error = err_n | (pend_n != PendNone);
			res.unit_total   = count_n;
			nxt              = '0;
		end
	end
endmodule

FILE: hw/rtl/utf8_to_utf16_decoder.sv
// Top level of the UTF-8 to UTF-16 (BMP) decoder: sequence state and result register.
// Depends on u8u16_pkg, u8u16_byte_if, u8u16_unit_if and u8u16_decode.
//
//   channel   dir  payload                                   transfer when
//   byte_ch   in   byte_in, last_byte                        valid && ready
//   unit_ch   out  unit_valid, code_unit, byte_error,        valid && ready
//                  string_end, string_error, unit_total
//
// Every byte transfer yields exactly one result transfer from the result register.
// Throughput is one byte per cycle while the sink keeps up; the result register is the only stage.
// A byte is taken whenever the result register is empty or is being drained
// in the same cycle, so a stalled sink holds one result and then stalls input.
// arst_n clears the sequence state and the result valid flag.
module utf8_to_utf16_decoder (
	input  logic         clk,
	input  logic         arst_n,
	u8u16_byte_if.sink   byte_ch,
	u8u16_unit_if.source unit_ch
);
	import u8u16_pkg::*;

	dec_state_t  state_q;
	dec_state_t  state_next;
	dec_result_t res_next;
	dec_result_t res_s1;
	logic        valid_s1;
	logic        take;

	// Accept when the result slot is free or frees up this cycle.
	assign byte_ch.ready = !valid_s1 || unit_ch.ready;
	assign take          = byte_ch.valid && byte_ch.ready;

	u8u16_decode u_decode (
		.cur       (state_q),
		.byte_in   (byte_ch.byte_in),
		.last_byte (byte_ch.last_byte),
		.nxt       (state_next),
		.res       (res_next)
	);

	// Sequence state: advance only on a byte transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (take) begin
			state_q <= state_next;
		end
	end

	// Result valid: set on a byte transfer, drop once the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (unit_ch.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// Result payload: load with each new byte, hold while stalled.
	always_ff @(posedge clk) begin
		if (take) begin
			res_s1 <= res_next;
		end
	end

	assign unit_ch.valid        = valid_s1;
	assign unit_ch.unit_valid   = res_s1.unit_valid;
	assign unit_ch.code_unit    = res_s1.code_unit;
	assign unit_ch.byte_error   = res_s1.byte_error;
	assign unit_ch.string_end   = res_s1.string_end;
	assign unit_ch.string_error = res_s1.string_error;
	assign unit_ch.unit_total   = res_s1.unit_total;
endmodule

FILE: verif/tb_utf8_to_utf16_decoder.sv
// Testbench for utf8_to_utf16_decoder: drives UTF-8 byte strings with random gaps and
// back-pressure, predicts every result in a local decoder and checks it field by field.
// Depends on u8u16_pkg, u8u16_byte_if, u8u16_unit_if and the decoder RTL.
module tb_utf8_to_utf16_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import u8u16_pkg::*;

	typedef logic [ByteW-1:0] utf8_str_t[$];

	logic clk;
	logic arst_n;

	u8u16_byte_if byte_ch();
	u8u16_unit_if unit_ch();

	utf8_to_utf16_decoder i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_ch (byte_ch),
		.unit_ch (unit_ch)
	);

	// Decoder state mirrored by the predictor.
	logic [PendW-1:0]  cont_left;
	logic [PartW-1:0]  gathered_bits;
	logic              string_broken;
	logic [CountW-1:0] units_in_string;

	// Decoded results waiting for their output transfer, oldest first.
	dec_result_t decoded_results[$];

	int unsigned mismatch_count;
	int unsigned bytes_sent;

	// Idle controls: tx_gaps/rx_stalls enable the random waits per transfer,
	// rx_hold_cycles asks the receiver for one long hold-off.
	bit tx_gaps;
	bit rx_stalls;
	int unsigned rx_hold_cycles;

	// Clock: 12 ns period.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: a correct run ends long before this.
	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Decode one byte the way the block must, update the mirrored state and
	// return the result that its transfer produces.
	function automatic dec_result_t decode_utf8_byte(input logic [ByteW-1:0] b,
		input logic last);
		dec_result_t res;
		logic [UnitW-1:0] joined;
		res = '0;
		if (cont_left != PendNone && b[7:6] == ContTag) begin
			// Continuation: shift the payload in, emit once the sequence closes.
			joined = {gathered_bits, b[5:0]};
			if (cont_left == PendOne) begin
				res.unit_valid = 1'b1;
				res.code_unit  = joined;
				cont_left      = PendNone;
				gathered_bits  = '0;
			end else begin
				gathered_bits = joined[PartW-1:0];
				cont_left     = PendOne;
			end
		end else begin
			// A missing continuation drops the open sequence; the byte is then
			// decoded again as a lead in the same step.
			if (cont_left != PendNone) begin
				res.byte_error = 1'b1;
				cont_left      = PendNone;
				gathered_bits  = '0;
			end
			if (!b[7]) begin
				res.unit_valid = 1'b1;
				res.code_unit  = {8'h00, b};
			end else if (b[7:5] == Lead2Tag) begin
				cont_left     = PendOne;
				gathered_bits = {5'b0, b[4:0]};
			end else if (b[7:4] == Lead3Tag) begin
				cont_left     = PendTwo;
				gathered_bits = {6'b0, b[3:0]};
			end else begin
				// Stray continuation or a four-byte-and-up lead: flag and skip.
				res.byte_error = 1'b1;
			end
		end
		if (res.unit_valid && units_in_string != CountMax)
			units_in_string++;
		if (res.byte_error)
			string_broken = 1'b1;
		res.string_end = last;
		if (last) begin
			// A sequence still open at the end of the string is a truncation error.
			if (cont_left != PendNone)
				string_broken = 1'b1;
			res.string_error = string_broken;
			res.unit_total   = units_in_string;
			cont_left        = PendNone;
			gathered_bits    = '0;
			string_broken    = 1'b0;
			units_in_string  = '0;
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		mismatch_count++;
		$display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	// Scoreboard: check the output transfer against the oldest decoded result,
	// then predict the input transfer of the same edge. A result is registered
	// after its byte is taken, so the order of the two never matters.
	always @(posedge clk) begin
		dec_result_t want;
		if (arst_n) begin
			if (unit_ch.valid && unit_ch.ready) begin
				if (decoded_results.size() == 0) begin
					report_mismatch("unexpected result", unit_ch.code_unit, 0);
				end else begin
					want = decoded_results.pop_front();
					if (unit_ch.unit_valid !== want.unit_valid)
						report_mismatch("unit_valid", unit_ch.unit_valid, want.unit_valid);
					if (unit_ch.code_unit !== want.code_unit)
						report_mismatch("code_unit", unit_ch.code_unit, want.code_unit);
					if (unit_ch.byte_error !== want.byte_error)
						report_mismatch("byte_error", unit_ch.byte_error, want.byte_error);
					if (unit_ch.string_end !== want.string_end)
						report_mismatch("string_end", unit_ch.string_end, want.string_end);
					if (unit_ch.string_error !== want.string_error)
						report_mismatch("string_error", unit_ch.string_error,
							want.string_error);
					if (unit_ch.unit_total !== want.unit_total)
						report_mismatch("unit_total", unit_ch.unit_total, want.unit_total);
				end
			end
			if (byte_ch.valid && byte_ch.ready)
				decoded_results.push_back(decode_utf8_byte(byte_ch.byte_in,
					byte_ch.last_byte));
		end
	end

	// Receiver: draw a stall before each transfer, or hold off for a long
	// stretch when asked. Raise ready only once per step.
	initial begin
		int unsigned stall;
		unit_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = rx_stalls ? $urandom_range(0, 6) : 0;
			if (rx_hold_cycles != 0) begin
				stall          = rx_hold_cycles;
				rx_hold_cycles = 0;
			end
			if (stall != 0) begin
				unit_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			unit_ch.ready <= 1'b1;
			do @(posedge clk); while (!(unit_ch.valid && unit_ch.ready));
		end
	end

	// Offer one byte after a random gap and hold it until the transfer. Valid
	// stays high on return so that back-to-back bytes keep it asserted.
	task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
		int unsigned gap;
		gap = tx_gaps ? $urandom_range(0, 6) : 0;
		if (gap != 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.byte_in   <= b;
		byte_ch.last_byte <= last;
		do @(posedge clk); while (!byte_ch.ready);
		bytes_sent++;
	endtask

	// Send a whole string; the final byte carries the end flag.
	task automatic send_string(input utf8_str_t s);
		foreach (s[i])
			send_byte(s[i], i == s.size() - 1);
	endtask

	// Drop valid and wait until every decoded result has been checked.
	task automatic drain_results();
		byte_ch.valid <= 1'b0;
		do @(posedge clk); while (decoded_results.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	// Well-formed strings: ASCII extremes, two- and three-byte forms, overlong
	// forms and surrogate code points, which all decode as written.
	task automatic test_valid_sequences();
		utf8_str_t s;
		tx_gaps   = 1'b1;
		rx_stalls = 1'b1;
		s = {8'h00, 8'h7F};
		send_string(s);
		s = {8'hC2, 8'hA9};
		send_string(s);
		s = {8'hE2, 8'h82, 8'hAC};
		send_string(s);
		s = {8'hC0, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hED, 8'hA0, 8'h80};
		send_string(s);
		drain_results();
	endtask

	// Malformed strings: stray continuation, invalid leads, missing
	// continuations re-taken as ASCII, as a new lead and as an invalid lead,
	// then truncation at the end of a string.
	task automatic test_malformed_sequences();
		utf8_str_t s;
		tx_gaps   = 1'b1;
		rx_stalls = 1'b1;
		s = {8'h80, 8'hF8, 8'hFF, 8'hF0};
		send_string(s);
		s = {8'hC3, 8'h41, 8'hE2, 8'h82, 8'hC3, 8'hA9, 8'hC3, 8'hFF};
		send_string(s);
		s = {8'hE2, 8'h82};
		send_string(s);
		s = {8'hC3};
		send_string(s);
		drain_results();
	endtask

	// Back-pressure: hold the receiver off for a long stretch while bytes keep
	// coming back to back, so the result register fills and stalls the input.
	task automatic test_output_stall();
		utf8_str_t s;
		tx_gaps        = 1'b0;
		rx_stalls      = 1'b0;
		rx_hold_cycles = 40;
		s = {8'h48, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'h6C, 8'h6F,
			8'hC2, 8'hB5, 8'h21, 8'hEF, 8'hBF, 8'hBD, 8'h7A, 8'h0A};
		send_string(s);
		drain_results();
	endtask

	// Random strings: mostly well-formed characters with random payload, mixed
	// with noise bytes, stray continuations and dangling leads. Idling switches
	// off for whole strings now and then.
	task automatic test_random_strings();
		utf8_str_t s;
		int unsigned start_count;
		int unsigned kind;
		logic [31:0] cp;
		start_count = bytes_sent;
		while (bytes_sent - start_count < 900) begin
			s.delete();
			tx_gaps   = ($urandom_range(0, 3) != 0);
			rx_stalls = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(1, 10)) begin
				kind = $urandom_range(0, 19);
				cp   = $urandom();
				if (kind < 5) begin
					s.push_back({1'b0, cp[6:0]});
				end else if (kind < 10) begin
					s.push_back({3'b110, cp[10:6]});
					s.push_back({2'b10, cp[5:0]});
				end else if (kind < 15) begin
					s.push_back({4'b1110, cp[15:12]});
					s.push_back({2'b10, cp[11:6]});
					s.push_back({2'b10, cp[5:0]});
				end else if (kind < 17) begin
					s.push_back(cp[7:0]);
				end else if (kind < 18) begin
					s.push_back({2'b10, cp[5:0]});
				end else if (kind < 19) begin
					s.push_back({4'b1110, cp[3:0]});
					if (cp[8])
						s.push_back({2'b10, cp[15:10]});
				end else begin
					s.push_back({3'b110, cp[4:0]});
				end
			end
			send_string(s);
		end
		drain_results();
	endtask

	// Main sequence: reset once, run the tests in turn, report.
	initial begin
		mismatch_count  = 0;
		bytes_sent      = 0;
		tx_gaps         = 1'b0;
		rx_stalls       = 1'b0;
		rx_hold_cycles  = 0;
		cont_left       = PendNone;
		gathered_bits   = '0;
		string_broken   = 1'b0;
		units_in_string = '0;
		arst_n            <= 1'b0;
		byte_ch.valid     <= 1'b0;
		byte_ch.byte_in   <= '0;
		byte_ch.last_byte <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_valid_sequences();
		test_malformed_sequences();
		test_output_stall();
		test_random_strings();

		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
